FILE: design/cfm_pkg.sv
// Package for the Chapman factor matrix core: field widths, register codes,
// reset values, step counts and the sequencer state type. No dependencies.
package cfm_pkg;

   localparam int ALT_W = 22;
   localparam int ER_W = 27;
   localparam int CZ_W = 17;
   localparam int LC_W = 7;
   localparam int IDX_W = 6;
   localparam int FAC_W = 24;
   localparam int RAD_W = 28;
   localparam int SQ_W = 56;
   localparam int CSR_W = 27;
   localparam int CSR_IDX_W = 2;
   localparam int S_W = 33;
   localparam int DVD_W = 45;
   localparam int ROOT_W = 32;
   localparam int CNT_W = 6;

   localparam int MUL_STEPS = 33;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS = 45;

   localparam logic [FAC_W-1:0] FACTOR_MAX = '1;
   localparam logic [ER_W-1:0] EARTH_RADIUS_RST = 27'd101936000;
   localparam logic [CZ_W-1:0] COS_ZENITH_RST = 17'd65536;
   localparam logic [LC_W-1:0] LAYER_COUNT_RST = 7'd32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EARTH_RADIUS = 2'd0,
      CSR_COS_ZENITH = 2'd1,
      CSR_PSEUDO_SPHERICAL = 2'd2,
      CSR_LAYER_COUNT = 2'd3
   } csr_index_type;

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_RD_P   = 17'h00002,
      ST_GET_P  = 17'h00004,
      ST_SQ_P   = 17'h00008,
      ST_MUL_D  = 17'h00010,
      ST_DIV    = 17'h00020,
      ST_COL    = 17'h00040,
      ST_RD_F   = 17'h00080,
      ST_GET_F  = 17'h00100,
      ST_SQ_A   = 17'h00200,
      ST_LD_A   = 17'h00400,
      ST_SQRT_A = 17'h00800,
      ST_SQ_B   = 17'h01000,
      ST_LD_B   = 17'h02000,
      ST_SQRT_B = 17'h04000,
      ST_DIV_LD = 17'h08000,
      ST_EMIT   = 17'h10000
   } state_type;

endpackage

FILE: design/cfm_req_if.sv
// Request channel interface of the Chapman factor matrix core.
// Depends on cfm_pkg for field widths.
interface cfm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [cfm_pkg::IDX_W-1:0]   layer_index;
   logic [cfm_pkg::ALT_W-1:0]   altitude;

   modport source (output valid, mode, layer_index, altitude, input ready);
   modport sink (input valid, mode, layer_index, altitude, output ready);
endinterface

FILE: design/cfm_rsp_if.sv
// Response channel interface of the Chapman factor matrix core.
// Depends on cfm_pkg for field widths.
interface cfm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cfm_pkg::IDX_W-1:0]   row_index;
   logic [cfm_pkg::IDX_W-1:0]   column_index;
   logic [cfm_pkg::FAC_W-1:0]   factor;
   logic                        zero_thickness;
   logic                        last;

   modport source (output valid, row_index, column_index, factor, zero_thickness, last,
                   input ready);
   modport sink (input valid, row_index, column_index, factor, zero_thickness, last,
                 output ready);
endinterface

FILE: design/chapman_factor_matrix_core.sv
// Chapman factor matrix core. A load item is stored when accepted. A compute item for row p
// emits L items: a setup after the accept (read, square and the 33-step serial rp^2*s
// product), then per column on or below the diagonal two 32-step passes of one root
// unit and one 45-step divider, all radix 2; a zero-thickness column, a column above
// the diagonal or a column in plane mode skips these. Output stalls can hold each item.
// Plane mode adds one 45-step division per row unless the cosine is zero. Reset is
// synchronous, active high: control and configuration registers take their reset values
// and the sequencer idles; the boundary RAM and payload registers are not cleared.
module chapman_factor_matrix_core #(
   parameter int MAX_LAYERS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   cfm_req_if.sink                         req_ch,
   cfm_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [cfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfm_pkg::CSR_W-1:0]       csr_wr_data
);

   localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int CAP = (MAX_LAYERS < 64) ? MAX_LAYERS : 64;

   // Configuration registers
   logic [cfm_pkg::ER_W-1:0] er_ff;
   logic [cfm_pkg::CZ_W-1:0] cz_ff;
   logic                     ps_ff;
   logic [cfm_pkg::LC_W-1:0] lc_ff;

   // Sequencer and datapath registers
   cfm_pkg::state_type state_ff, state_in;
   logic [cfm_pkg::IDX_W-1:0]  row_ff, row_in;
   logic [cfm_pkg::IDX_W-1:0]  q_ff, q_in;
   logic [cfm_pkg::LC_W-1:0]   n_ff, n_in;
   logic [cfm_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [cfm_pkg::RAD_W-1:0]  rp_ff, rp_in, rc_ff, rc_in, rf_ff, rf_in;
   logic [cfm_pkg::S_W-1:0]    s_ff, s_in;
   logic [cfm_pkg::SQ_W-1:0]   rp2_ff, rp2_in, d_ff, d_in, sq_ff, sq_in;
   logic [cfm_pkg::ALT_W-1:0]  ca_ff, ca_in, thick_ff, thick_in;
   logic [63:0]                x_ff, x_in;
   logic [32:0]                rem_ff, rem_in;
   logic [cfm_pkg::ROOT_W-1:0] root_ff, root_in, sa_ff, sa_in;
   logic [cfm_pkg::DVD_W-1:0]  dvd_ff, dvd_in, quo_ff, quo_in;
   logic [cfm_pkg::ALT_W-1:0]  dvs_ff, dvs_in, drem_ff, drem_in;
   logic [cfm_pkg::FAC_W-1:0]  pf_ff, pf_in, fac_ff, fac_in;
   logic                       flag_ff, flag_in;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cfm_pkg::IDX_W-1:0]  rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [cfm_pkg::FAC_W-1:0]  rsp_fac_ff, rsp_fac_in;
   logic                       rsp_zt_ff, rsp_zt_in, rsp_last_ff, rsp_last_in;

   // Boundary RAM
   logic                       ram_we;
   logic [AW-1:0]              ram_waddr, ram_raddr;
   logic [cfm_pkg::ALT_W-1:0]  ram_rdata;

   logic [cfm_pkg::LC_W-1:0]   lc_n;
   logic [cfm_pkg::IDX_W-1:0]  nm1;
   logic                       req_fire;

   // Combinational step values
   logic [33:0]                cz2;
   logic [cfm_pkg::ALT_W-1:0]  fa;
   logic [cfm_pkg::SQ_W:0]     mul_sum;
   logic [34:0]                sq_tr, sq_trial;
   logic                       sq_ge;
   logic [cfm_pkg::ALT_W:0]    dv_tr;
   logic                       dv_ge;
   logic [cfm_pkg::FAC_W-1:0]  quo_sat;
   logic [cfm_pkg::ROOT_W-1:0] num;

   cfm_ram #(.WIDTH(cfm_pkg::ALT_W), .DEPTH(MAX_LAYERS)) u_bnd_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_ch.altitude),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Layers in use: zero counts as one, clip at the storage depth, at most 64
   always_comb begin
      if (lc_ff == '0) begin
         lc_n = cfm_pkg::LC_W'(1);
      end else if (32'(lc_ff) > CAP) begin
         lc_n = cfm_pkg::LC_W'(CAP);
      end else begin
         lc_n = lc_ff;
      end
   end

   assign nm1 = cfm_pkg::IDX_W'(n_ff - 1'b1);
   assign req_ch.ready = (state_ff == cfm_pkg::ST_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;

   // Store boundaries on load items; indices past the store are dropped
   assign ram_we = req_fire && !req_ch.mode && (32'(req_ch.layer_index) < MAX_LAYERS);
   assign ram_waddr = AW'(req_ch.layer_index);

   // Serial step datapaths
   assign cz2 = cz_ff * cz_ff;
   assign fa = (q_ff == nm1) ? '0 : ram_rdata;
   assign mul_sum = {1'b0, d_ff} + (s_ff[0] ? {1'b0, rp2_ff} : '0);
   assign sq_tr = {rem_ff, x_ff[63:62]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge = (sq_tr >= sq_trial);
   assign dv_tr = {drem_ff, dvd_ff[cfm_pkg::DVD_W-1]};
   assign dv_ge = (dv_tr >= {1'b0, dvs_ff});
   assign quo_sat = (quo_ff[cfm_pkg::DVD_W-1:cfm_pkg::FAC_W] != '0) ?
                    cfm_pkg::FACTOR_MAX : quo_ff[cfm_pkg::FAC_W-1:0];
   assign num = (sa_ff >= root_ff) ? (sa_ff - root_ff) : (root_ff - sa_ff);

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      q_in = q_ff;
      n_in = n_ff;
      cnt_in = cnt_ff;
      rp_in = rp_ff;
      rc_in = rc_ff;
      rf_in = rf_ff;
      s_in = s_ff;
      rp2_in = rp2_ff;
      d_in = d_ff;
      sq_in = sq_ff;
      ca_in = ca_ff;
      thick_in = thick_ff;
      x_in = x_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      sa_in = sa_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      drem_in = drem_ff;
      pf_in = pf_ff;
      fac_in = fac_ff;
      flag_in = flag_ff;
      ram_raddr = AW'(q_ff);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_fac_in = rsp_fac_ff;
      rsp_zt_in = rsp_zt_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         cfm_pkg::ST_IDLE: begin
            // Take a compute item only if its row lies within the layers in use
            if (req_fire && req_ch.mode) begin
               row_in = req_ch.layer_index;
               n_in = lc_n;
               if ({1'b0, req_ch.layer_index} < lc_n) begin
                  state_in = cfm_pkg::ST_RD_P;
               end
            end
         end
         cfm_pkg::ST_RD_P: begin
            ram_raddr = AW'({1'b0, row_ff} + 7'd1);
            state_in = cfm_pkg::ST_GET_P;
         end
         cfm_pkg::ST_GET_P: begin
            // Radius of the row floor and s = 1 - cos^2 in Q1.32
            rp_in = cfm_pkg::RAD_W'(er_ff) +
                    cfm_pkg::RAD_W'((row_ff == nm1) ? '0 : ram_rdata);
            s_in = (cz2[33:32] != 2'b00) ? '0 : cfm_pkg::S_W'(34'h1_0000_0000 - cz2);
            state_in = cfm_pkg::ST_SQ_P;
         end
         cfm_pkg::ST_SQ_P: begin
            rp2_in = rp_ff * rp_ff;
            d_in = '0;
            cnt_in = '0;
            state_in = cfm_pkg::ST_MUL_D;
         end
         cfm_pkg::ST_MUL_D: begin
            // Shift-add one bit of s per cycle, dropping the low bits as we go
            s_in = s_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cfm_pkg::CNT_W'(cfm_pkg::MUL_STEPS - 1)) begin
               d_in = mul_sum[cfm_pkg::SQ_W-1:0];
               q_in = '0;
               if (ps_ff) begin
                  state_in = cfm_pkg::ST_COL;
               end else if (cz_ff == '0) begin
                  pf_in = cfm_pkg::FACTOR_MAX;
                  state_in = cfm_pkg::ST_COL;
               end else begin
                  // Secant: (2^32 + cos/2) / cos
                  dvd_in = cfm_pkg::DVD_W'(33'h1_0000_0000) +
                           cfm_pkg::DVD_W'(cz_ff >> 1);
                  dvs_in = cfm_pkg::ALT_W'(cz_ff);
                  drem_in = '0;
                  quo_in = '0;
                  cnt_in = '0;
                  state_in = cfm_pkg::ST_DIV;
               end
            end else begin
               d_in = mul_sum[cfm_pkg::SQ_W:1];
            end
         end
         cfm_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle
            dvd_in = dvd_ff << 1;
            drem_in = dv_ge ? cfm_pkg::ALT_W'(dv_tr - {1'b0, dvs_ff}) :
                              cfm_pkg::ALT_W'(dv_tr);
            quo_in = {quo_ff[cfm_pkg::DVD_W-2:0], dv_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cfm_pkg::CNT_W'(cfm_pkg::DIV_STEPS - 1)) begin
               if (!ps_ff) begin
                  // Hold the saturated secant for every column of the row
                  pf_in = (quo_in[cfm_pkg::DVD_W-1:cfm_pkg::FAC_W] != '0) ?
                          cfm_pkg::FACTOR_MAX : quo_in[cfm_pkg::FAC_W-1:0];
               end
               state_in = ps_ff ? cfm_pkg::ST_EMIT : cfm_pkg::ST_COL;
            end
         end
         cfm_pkg::ST_COL: begin
            if (!ps_ff) begin
               fac_in = pf_ff;
               flag_in = 1'b0;
               state_in = cfm_pkg::ST_EMIT;
            end else if (q_ff > row_ff) begin
               fac_in = '0;
               flag_in = 1'b0;
               state_in = cfm_pkg::ST_EMIT;
            end else begin
               ram_raddr = AW'(q_ff);
               state_in = cfm_pkg::ST_RD_F;
            end
         end
         cfm_pkg::ST_RD_F: begin
            ca_in = ram_rdata;
            ram_raddr = AW'({1'b0, q_ff} + 7'd1);
            state_in = cfm_pkg::ST_GET_F;
         end
         cfm_pkg::ST_GET_F: begin
            rc_in = cfm_pkg::RAD_W'(er_ff) + cfm_pkg::RAD_W'(ca_ff);
            rf_in = cfm_pkg::RAD_W'(er_ff) + cfm_pkg::RAD_W'(fa);
            thick_in = (ca_ff >= fa) ? (ca_ff - fa) : (fa - ca_ff);
            if (ca_ff == fa) begin
               fac_in = cfm_pkg::FACTOR_MAX;
               flag_in = 1'b1;
               state_in = cfm_pkg::ST_EMIT;
            end else begin
               flag_in = 1'b0;
               state_in = cfm_pkg::ST_SQ_A;
            end
         end
         cfm_pkg::ST_SQ_A: begin
            sq_in = rc_ff * rc_ff;
            state_in = cfm_pkg::ST_LD_A;
         end
         cfm_pkg::ST_LD_A, cfm_pkg::ST_LD_B: begin
            // Clamp the radicand at zero and scale for four fraction bits
            x_in = {((sq_ff > d_ff) ? (sq_ff - d_ff) : '0), 8'h00};
            rem_in = '0;
            root_in = '0;
            cnt_in = '0;
            state_in = (state_ff == cfm_pkg::ST_LD_A) ? cfm_pkg::ST_SQRT_A :
                                                         cfm_pkg::ST_SQRT_B;
         end
         cfm_pkg::ST_SQRT_A, cfm_pkg::ST_SQRT_B: begin
            // Digit-by-digit root, two radicand bits per cycle
            x_in = x_ff << 2;
            rem_in = sq_ge ? 33'(sq_tr - sq_trial) : 33'(sq_tr);
            root_in = {root_ff[cfm_pkg::ROOT_W-2:0], sq_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cfm_pkg::CNT_W'(cfm_pkg::SQRT_STEPS - 1)) begin
               state_in = (state_ff == cfm_pkg::ST_SQRT_A) ? cfm_pkg::ST_SQ_B :
                                                              cfm_pkg::ST_DIV_LD;
            end
         end
         cfm_pkg::ST_SQ_B: begin
            sa_in = root_ff;
            sq_in = rf_ff * rf_ff;
            state_in = cfm_pkg::ST_LD_B;
         end
         cfm_pkg::ST_DIV_LD: begin
            // Ratio rounded half up: (num * 2^12 + thick/2) / thick
            dvd_in = {1'b0, num, 12'h000} + cfm_pkg::DVD_W'(thick_ff >> 1);
            dvs_in = thick_ff;
            drem_in = '0;
            quo_in = '0;
            cnt_in = '0;
            state_in = cfm_pkg::ST_DIV;
         end
         cfm_pkg::ST_EMIT: begin
            // Hand the factor to the output register once it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in = row_ff;
               rsp_col_in = q_ff;
               rsp_fac_in = (state_ff == cfm_pkg::ST_EMIT && ps_ff && !flag_ff &&
                             q_ff <= row_ff) ? quo_sat : fac_ff;
               rsp_zt_in = flag_ff;
               rsp_last_in = (q_ff == nm1);
               if (q_ff == nm1) begin
                  state_in = cfm_pkg::ST_IDLE;
               end else begin
                  q_in = q_ff + 1'b1;
                  state_in = cfm_pkg::ST_COL;
               end
            end
         end
         default: begin
            state_in = cfm_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         er_ff <= cfm_pkg::EARTH_RADIUS_RST;
         cz_ff <= cfm_pkg::COS_ZENITH_RST;
         ps_ff <= 1'b1;
         lc_ff <= cfm_pkg::LAYER_COUNT_RST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         if (csr_wr_en) begin
            unique case (cfm_pkg::csr_index_type'(csr_index))
               cfm_pkg::CSR_EARTH_RADIUS: er_ff <= csr_wr_data[cfm_pkg::ER_W-1:0];
               cfm_pkg::CSR_COS_ZENITH: cz_ff <= csr_wr_data[cfm_pkg::CZ_W-1:0];
               cfm_pkg::CSR_PSEUDO_SPHERICAL: ps_ff <= csr_wr_data[0];
               cfm_pkg::CSR_LAYER_COUNT: lc_ff <= csr_wr_data[cfm_pkg::LC_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      q_ff <= q_in;
      n_ff <= n_in;
      rp_ff <= rp_in;
      rc_ff <= rc_in;
      rf_ff <= rf_in;
      s_ff <= s_in;
      rp2_ff <= rp2_in;
      d_ff <= d_in;
      sq_ff <= sq_in;
      ca_ff <= ca_in;
      thick_ff <= thick_in;
      x_ff <= x_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      sa_ff <= sa_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      drem_ff <= drem_in;
      pf_ff <= pf_in;
      fac_ff <= fac_in;
      flag_ff <= flag_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_fac_ff <= rsp_fac_in;
      rsp_zt_ff <= rsp_zt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.row_index = rsp_row_ff;
   assign rsp_ch.column_index = rsp_col_ff;
   assign rsp_ch.factor = rsp_fac_ff;
   assign rsp_ch.zero_thickness = rsp_zt_ff;
   assign rsp_ch.last = rsp_last_ff;

`ifndef SYNTHESIS
   zt_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_zt_ff |-> rsp_fac_ff == cfm_pkg::FACTOR_MAX)
      else $error("zero-thickness item without saturated factor");

   last_on_final_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_col_ff == nm1)
      else $error("last flag off the final column");

   upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ps_ff && (rsp_col_ff > rsp_row_ff) |->
         rsp_fac_ff == '0 && !rsp_zt_ff)
      else $error("nonzero factor above the diagonal");

   emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == cfm_pkg::ST_EMIT && !(rsp_valid_ff && !rsp_ch.ready) |=> rsp_valid_ff)
      else $error("emitted item lost");
`endif

endmodule

FILE: design/cfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfm_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
